[src/spos_pkg.sv]
// spos_pkg: shared types and constants of the shuffled play-order sequencer
// request and response structs, command, status and register codes
// no dependencies
`default_nettype none

package spos_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int RANDOM_BITS_DEF = 31;

    localparam int CMD_W    = 2;
    localparam int LEN_W    = 11;
    localparam int WORD_W   = 31;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_RELOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WORD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RELOADED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SWAP     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REJECT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_END      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_UNUSED   = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_SHUFFLE_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART    = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [LEN_W-1:0]  list_length;
        logic [WORD_W-1:0] random_word;
    } t_in_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  entry_index;
        logic                shuffle_done;
    } t_out_rsp;

endpackage

`default_nettype wire

[src/spos_rem_unit.sv]
// spos_rem_unit: restoring remainder unit, one dividend bit per cycle
// standalone, no package dependencies
`default_nettype none

module spos_rem_unit #(
    parameter int DW = 31,
    parameter int RW = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [RW-1:0] i_divisor,
    output logic               o_done,
    output logic [RW-1:0]      o_rem
);

    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_dvd;
    logic [RW-1:0]   r_div;
    logic [RW-1:0]   r_rem;
    logic [RW:0]     n_shift;
    logic [RW-1:0]   n_rem;

    always_comb begin
        n_shift = {r_rem, r_dvd[DW-1]};
        if (n_shift >= {1'b0, r_div}) begin
            n_rem = RW'(n_shift - {1'b0, r_div});
        end else begin
            n_rem = RW'(n_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[src/spos_order_ram.sv]
// spos_order_ram: play-order table, one write and one registered read port
// standalone, no package dependencies
`default_nettype none

module spos_order_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [AW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [AW-1:0]      o_rdata
);

    logic [AW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/shuffled_play_order_sequencer.sv]
// shuffled_play_order_sequencer: top level, command sequencer around the
// order table and the shared remainder unit; uses spos_pkg, spos_rem_unit, spos_order_ram
//
//   channel   signals                               direction
//   request   i_in_valid / o_in_ready / i_in        in
//   response  o_out_valid / i_out_ready / o_out     out
//   config    i_cfg_valid / o_cfg_ready / i_cfg_*   in
//
// reload: identity fill of the table, one entry a cycle, then the response
// random word: the bit-serial remainder unit, then for a swap the four table accesses
//   (read i, read j, write j, write i); a rejected word skips the table accesses
// next entry: a registered table read; other requests answer directly; one request at a time
// synchronous active-low reset; table contents undefined until a reload
// a full response register stalls completion, not acceptance
`default_nettype none

module shuffled_play_order_sequencer #(
    parameter int DEPTH       = spos_pkg::DEPTH_DEF,
    parameter int RANDOM_BITS = spos_pkg::RANDOM_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire spos_pkg::t_in_req                i_in,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output spos_pkg::t_out_rsp                    o_out,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [spos_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic                             i_cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > spos_pkg::LEN_W) ? CW : spos_pkg::LEN_W;
    localparam int RB = RANDOM_BITS;
    localparam int SW = ((RB > CW) ? RB : CW) + 1;
    localparam logic [SW-1:0] RMAX = {{(SW - RB){1'b0}}, {RB{1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE, S_FILL, S_DIV, S_RD_I, S_RD_J, S_WR_J, S_WR_I,
        S_RD_PLAY, S_GET, S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_list_count, n_list_count;
    logic [CW-1:0]      r_play_pos, n_play_pos;
    logic [CW-1:0]      r_shuf_pos, n_shuf_pos;
    logic               r_shuf_active, n_shuf_active;
    logic               r_shuffle_en, n_shuffle_en;
    logic               r_stop_end, n_stop_end;
    logic               r_restart, n_restart;
    logic [CW-1:0]      r_idx, n_idx;
    logic [RB-1:0]      r_word, n_word;
    logic [AW-1:0]      r_j, n_j;
    logic [AW-1:0]      r_tmp_i, n_tmp_i;
    logic [AW-1:0]      r_tmp_j, n_tmp_j;
    spos_pkg::t_out_rsp r_res, n_res;
    spos_pkg::t_out_rsp r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               in_acc;
    logic [LW-1:0]      len_ext;
    logic [CW-1:0]      new_count;
    logic [CW-1:0]      range;
    logic [CW-1:0]      shuf_inc;
    logic [SW-1:0]      top_sum;
    logic               div_start;
    logic               div_done;
    logic [CW-1:0]      div_rem;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [AW-1:0]      ram_rdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign in_acc      = i_in_valid && o_in_ready;

    assign len_ext   = LW'(i_in.list_length);
    assign new_count = (len_ext > LW'(DEPTH)) ? CW'(DEPTH) : CW'(len_ext);
    assign range     = r_list_count - r_shuf_pos;
    assign shuf_inc  = r_shuf_pos + CW'(1);
    // next multiple of range above the word's own multiple
    assign top_sum   = SW'(r_word) - SW'(div_rem) + SW'(range);

    spos_rem_unit #(
        .DW (RB),
        .RW (CW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (RB'(i_in.random_word)),
        .i_divisor  (range),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    spos_order_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_list_count  = r_list_count;
        n_play_pos    = r_play_pos;
        n_shuf_pos    = r_shuf_pos;
        n_shuf_active = r_shuf_active;
        n_shuffle_en  = r_shuffle_en;
        n_stop_end    = r_stop_end;
        n_restart     = r_restart;
        n_idx         = r_idx;
        n_word        = r_word;
        n_j           = r_j;
        n_tmp_i       = r_tmp_i;
        n_tmp_j       = r_tmp_j;
        n_res         = r_res;
        n_out         = r_out;
        n_out_valid   = r_out_valid;
        div_start     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_idx[AW-1:0];
        ram_wdata     = r_idx[AW-1:0];
        ram_raddr     = r_play_pos[AW-1:0];

        if (i_cfg_valid) begin
            case (i_cfg_index)
                spos_pkg::CFG_SHUFFLE_EN: n_shuffle_en = i_cfg_data;
                spos_pkg::CFG_STOP_END:   n_stop_end   = i_cfg_data;
                spos_pkg::CFG_RESTART:    n_restart    = i_cfg_data;
                default: ;
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res.entry_index  = '0;
                    n_res.shuffle_done = !r_shuf_active;
                    n_state            = S_EMIT;
                    case (i_in.cmd)
                        spos_pkg::CMD_RELOAD: begin
                            n_list_count  = new_count;
                            if (r_restart) begin
                                n_play_pos = '0;
                            end
                            n_shuf_pos    = '0;
                            n_shuf_active = r_shuffle_en && (new_count != '0);
                            n_res.status  = spos_pkg::ST_RELOADED;
                            n_res.shuffle_done = !(r_shuffle_en && (new_count != '0));
                            n_idx         = '0;
                            if (new_count != '0) begin
                                n_state = S_FILL;
                            end
                        end
                        spos_pkg::CMD_WORD: begin
                            if (r_shuf_active && (r_shuf_pos < r_list_count)) begin
                                div_start = 1'b1;
                                n_word    = RB'(i_in.random_word);
                                n_state   = S_DIV;
                            end else begin
                                n_res.status = spos_pkg::ST_UNUSED;
                            end
                        end
                        spos_pkg::CMD_NEXT: begin
                            if (r_shuf_active) begin
                                n_res.status = spos_pkg::ST_BUSY;
                            end else if (r_list_count == '0) begin
                                n_res.status = spos_pkg::ST_EMPTY;
                            end else if (r_play_pos >= r_list_count) begin
                                if (r_stop_end) begin
                                    n_res.status = spos_pkg::ST_END;
                                end else begin
                                    n_play_pos = '0;
                                    if (r_shuffle_en) begin
                                        n_shuf_pos         = '0;
                                        n_shuf_active      = 1'b1;
                                        n_res.status       = spos_pkg::ST_BUSY;
                                        n_res.shuffle_done = 1'b0;
                                    end else begin
                                        n_state = S_RD_PLAY;
                                    end
                                end
                            end else begin
                                n_state = S_RD_PLAY;
                            end
                        end
                        default: begin
                            n_res.status = spos_pkg::ST_UNUSED;
                        end
                    endcase
                end
            end
            S_FILL: begin
                ram_we = 1'b1;
                n_idx  = r_idx + CW'(1);
                if ((r_idx + CW'(1)) == r_list_count) begin
                    n_state = S_EMIT;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if ((div_rem != '0) && (top_sum > RMAX)) begin
                        n_res.status       = spos_pkg::ST_REJECT;
                        n_res.entry_index  = '0;
                        n_res.shuffle_done = 1'b0;
                        n_state            = S_EMIT;
                    end else begin
                        n_j     = AW'(r_shuf_pos + div_rem);
                        n_state = S_RD_I;
                    end
                end
            end
            S_RD_I: begin
                ram_raddr = r_shuf_pos[AW-1:0];
                n_state   = S_RD_J;
            end
            S_RD_J: begin
                ram_raddr = r_j;
                n_tmp_i   = ram_rdata;
                n_state   = S_WR_J;
            end
            S_WR_J: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_tmp_i;
                n_tmp_j   = ram_rdata;
                n_state   = S_WR_I;
            end
            S_WR_I: begin
                ram_we             = 1'b1;
                ram_waddr          = r_shuf_pos[AW-1:0];
                ram_wdata          = r_tmp_j;
                n_shuf_pos         = shuf_inc;
                n_shuf_active      = shuf_inc < r_list_count;
                n_res.status       = spos_pkg::ST_SWAP;
                n_res.entry_index  = '0;
                n_res.shuffle_done = !(shuf_inc < r_list_count);
                n_state            = S_EMIT;
            end
            S_RD_PLAY: begin
                ram_raddr = r_play_pos[AW-1:0];
                n_state   = S_GET;
            end
            S_GET: begin
                n_res.status       = spos_pkg::ST_ENTRY;
                n_res.entry_index  = spos_pkg::ENTRY_W'(ram_rdata);
                n_res.shuffle_done = 1'b1;
                n_play_pos         = r_play_pos + CW'(1);
                n_state            = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_list_count  <= '0;
            r_play_pos    <= '0;
            r_shuf_pos    <= '0;
            r_shuf_active <= 1'b0;
            r_shuffle_en  <= 1'b0;
            r_stop_end    <= 1'b0;
            r_restart     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_list_count  <= n_list_count;
            r_play_pos    <= n_play_pos;
            r_shuf_pos    <= n_shuf_pos;
            r_shuf_active <= n_shuf_active;
            r_shuffle_en  <= n_shuffle_en;
            r_stop_end    <= n_stop_end;
            r_restart     <= n_restart;
            r_out_valid   <= n_out_valid;
        end
        r_idx   <= n_idx;
        r_word  <= n_word;
        r_j     <= n_j;
        r_tmp_i <= n_tmp_i;
        r_tmp_j <= n_tmp_j;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
// testbench for shuffled_play_order_sequencer: directed and random request streams
// checked response by response against a predictor of the play-order table
// depends on spos_pkg and the sequencer rtl
`timescale 1ns / 1ps

module testbench;
    import spos_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam longint unsigned WORD_LIMIT = (64'd1 << RANDOM_BITS_DEF) - 1;
    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_FROM = RANDOM_ITEMS * 85 / 100;
    localparam int STALL_LIMIT = 10000;
    localparam int SETTLE_CYCLES = 100;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_req i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_rsp o_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic i_cfg_data = 1'b0;

    // predictor state
    int unsigned play_order [DEPTH_DEF];
    int unsigned list_cnt = 0;
    int unsigned play_ptr = 0;
    int unsigned shuf_ptr = 0;
    bit shuf_busy = 1'b0;
    bit cfg_shuffle = 1'b0;
    bit cfg_stop = 1'b0;
    bit cfg_restart = 1'b0;

    t_out_rsp awaited_answers [$];
    int failures = 0;
    int counted_items = 0;
    bit idle_on = 1'b1;

    shuffled_play_order_sequencer #(
        .DEPTH      (DEPTH_DEF),
        .RANDOM_BITS(RANDOM_BITS_DEF)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_out_rsp sequencer_answer(input t_in_req req);
        t_out_rsp ans;
        longint unsigned span;
        longint unsigned cap;
        longint unsigned w;
        int unsigned len;
        int unsigned j;
        int unsigned tmp;
        bit deliver;
        ans.status = ST_UNUSED;
        ans.entry_index = '0;
        case (req.cmd)
            CMD_RELOAD: begin
                len = req.list_length;
                list_cnt = (len > DEPTH_DEF) ? DEPTH_DEF : len;
                for (int k = 0; k < list_cnt; k++) play_order[k] = k;
                if (cfg_restart) play_ptr = 0;
                shuf_ptr = 0;
                shuf_busy = cfg_shuffle && (list_cnt > 0);
                ans.status = ST_RELOADED;
            end
            CMD_WORD: begin
                if (shuf_busy && shuf_ptr < list_cnt) begin
                    w = req.random_word & WORD_LIMIT;
                    span = list_cnt - shuf_ptr;
                    cap = WORD_LIMIT - (WORD_LIMIT % span);
                    if (w > cap) begin
                        ans.status = ST_REJECT;
                    end else begin
                        j = shuf_ptr + int'(w % span);
                        tmp = play_order[j];
                        play_order[j] = play_order[shuf_ptr];
                        play_order[shuf_ptr] = tmp;
                        shuf_ptr++;
                        if (shuf_ptr >= list_cnt) shuf_busy = 1'b0;
                        ans.status = ST_SWAP;
                    end
                end
            end
            CMD_NEXT: begin
                if (shuf_busy) begin
                    ans.status = ST_BUSY;
                end else if (list_cnt == 0) begin
                    ans.status = ST_EMPTY;
                end else begin
                    deliver = 1'b1;
                    if (play_ptr >= list_cnt) begin
                        if (cfg_stop) begin
                            ans.status = ST_END;
                            deliver = 1'b0;
                        end else begin
                            play_ptr = 0;
                            if (cfg_shuffle) begin
                                shuf_ptr = 0;
                                shuf_busy = 1'b1;
                                ans.status = ST_BUSY;
                                deliver = 1'b0;
                            end
                        end
                    end
                    if (deliver) begin
                        ans.entry_index = play_order[play_ptr][ENTRY_W-1:0];
                        play_ptr++;
                        ans.status = ST_ENTRY;
                    end
                end
            end
            default: ;
        endcase
        ans.shuffle_done = !shuf_busy;
        return ans;
    endfunction

    function automatic t_in_req make_req(input logic [CMD_W-1:0] code,
                                         input logic [LEN_W-1:0] length,
                                         input logic [WORD_W-1:0] word);
        t_in_req req;
        req.cmd = code;
        req.list_length = length;
        req.random_word = word;
        return req;
    endfunction

    task automatic send_request(input t_in_req req);
        t_out_rsp ans;
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        ans = sequencer_answer(req);
        awaited_answers.push_back(ans);
        if (ans.status != ST_UNUSED) counted_items++;
        if (counted_items >= QUIET_FROM) idle_on = 1'b0;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_answers.size() != 0);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input bit val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SHUFFLE_EN: cfg_shuffle = val;
            CFG_STOP_END:   cfg_stop = val;
            CFG_RESTART:    cfg_restart = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input bit shuffle_on, input bit stop_on,
                                  input bit restart_on);
        wait_drained();
        cfg_beat(CFG_SHUFFLE_EN, shuffle_on);
        cfg_beat(CFG_STOP_END, stop_on);
        cfg_beat(CFG_RESTART, restart_on);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_idle_requests();
        send_request(make_req(CMD_NEXT, '0, '0));
        send_request(make_req(CMD_WORD, '0, '0));
        send_request(make_req(CMD_SPARE, '1, '1));
        send_request(make_req(CMD_RELOAD, '0, '1));
    endtask

    task automatic test_stop_and_wrap();
        apply_settings(1'b0, 1'b0, 1'b0);
        send_request(make_req(CMD_RELOAD, LEN_W'(2), WORD_W'($urandom)));
        repeat (3) send_request(make_req(CMD_NEXT, LEN_W'($urandom), WORD_W'($urandom)));
        apply_settings(1'b0, 1'b1, 1'b0);
        // position survives the reload
        send_request(make_req(CMD_RELOAD, LEN_W'(2), WORD_W'($urandom)));
        repeat (3) send_request(make_req(CMD_NEXT, LEN_W'($urandom), WORD_W'($urandom)));
        // position now beyond the shorter list
        send_request(make_req(CMD_RELOAD, LEN_W'(1), WORD_W'($urandom)));
        send_request(make_req(CMD_NEXT, LEN_W'($urandom), WORD_W'($urandom)));
        apply_settings(1'b0, 1'b1, 1'b1);
        send_request(make_req(CMD_RELOAD, LEN_W'(1), WORD_W'($urandom)));
        send_request(make_req(CMD_NEXT, LEN_W'($urandom), WORD_W'($urandom)));
    endtask

    task automatic test_shuffle_steps();
        apply_settings(1'b1, 1'b0, 1'b1);
        send_request(make_req(CMD_RELOAD, LEN_W'(3), WORD_W'($urandom)));
        send_request(make_req(CMD_NEXT, '0, '0));
        send_request(make_req(CMD_WORD, '0, '1));
        send_request(make_req(CMD_WORD, '1, '0));
        send_request(make_req(CMD_WORD, '0, WORD_W'(1)));
        send_request(make_req(CMD_WORD, '0, WORD_W'(5)));
        // three entries, then the wrap starts a fresh shuffle
        repeat (4) send_request(make_req(CMD_NEXT, LEN_W'($urandom), WORD_W'($urandom)));
        send_request(make_req(CMD_RELOAD, '1, WORD_W'($urandom)));
        send_request(make_req(CMD_RELOAD, '0, WORD_W'($urandom)));
    endtask

    task automatic feed_shuffle();
        int budget;
        budget = (list_cnt > 16) ? $urandom_range(1, 24) : 4 * DEPTH_DEF;
        while (shuf_busy && budget > 0) begin
            case ($urandom_range(0, 29))
                0: send_request(make_req(CMD_NEXT, LEN_W'($urandom), WORD_W'($urandom)));
                1: send_request(make_req(CMD_RELOAD, LEN_W'(list_cnt), WORD_W'($urandom)));
                2, 3, 4: send_request(make_req(CMD_WORD, LEN_W'($urandom),
                                               WORD_W'(WORD_LIMIT - $urandom_range(0, 40))));
                default: send_request(make_req(CMD_WORD, LEN_W'($urandom),
                                               WORD_W'($urandom)));
            endcase
            budget--;
        end
    endtask

    task automatic play_through_list();
        int len;
        int plays;
        case ($urandom_range(0, 19))
            0: len = 0;
            1: len = $urandom_range(13, 2047);
            default: len = $urandom_range(1, 12);
        endcase
        send_request(make_req(CMD_RELOAD, LEN_W'(len), WORD_W'($urandom)));
        feed_shuffle();
        plays = $urandom_range(1, (list_cnt > 16) ? 20 : 2 * list_cnt + 3);
        repeat (plays) begin
            if ($urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    send_request(make_req(CMD_SPARE, LEN_W'($urandom), WORD_W'($urandom)));
                else
                    send_request(make_req(CMD_WORD, LEN_W'($urandom), WORD_W'($urandom)));
            end
            send_request(make_req(CMD_NEXT, LEN_W'($urandom), WORD_W'($urandom)));
            feed_shuffle();
        end
    endtask

    task automatic test_random_sessions();
        int session;
        logic [2:0] mode;
        session = 0;
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            mode = (session < 8) ? 3'(session) : 3'($urandom_range(0, 7));
            idle_on = (counted_items < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            apply_settings(mode[0], mode[1], mode[2]);
            repeat ($urandom_range(2, 6)) play_through_list();
            session++;
        end
    endtask

    initial begin : out_ready_gen
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold == 0 && idle_on && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 10);
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : answer_check
        t_out_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_answers.size() == 0) begin
                $error("response with no request outstanding: status %0d", o_out.status);
                failures++;
            end else begin
                want = awaited_answers.pop_front();
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out.status);
                    failures++;
                end
                if (o_out.entry_index !== want.entry_index) begin
                    $error("entry_index: expected %0d, got %0d",
                           want.entry_index, o_out.entry_index);
                    failures++;
                end
                if (o_out.shuffle_done !== want.shuffle_done) begin
                    $error("shuffle_done: expected %0d, got %0d",
                           want.shuffle_done, o_out.shuffle_done);
                    failures++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_requests();
        test_stop_and_wrap();
        test_shuffle_steps();
        test_random_sessions();
        idle_on = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
